### design/ilir_pkg.sv
// Shared constants, codes and types for the indexed list insert/remove unit.
package ilir_pkg;

    // Storage geometry
    localparam int DEPTH = 16;
    localparam int WIDTH = 32;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Fixed field widths of the request and response words
    localparam int REQ_W    = 3;
    localparam int INDEX_W  = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Width used to compare the request index against the count
    localparam int CMP_W = (INDEX_W > CNT_W) ? INDEX_W : CNT_W;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SET    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_GET    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_POP    = 3'd4;
    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd5;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd6;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    // Cell operation codes
    localparam logic [1:0] OP_HOLD     = 2'd0;
    localparam logic [1:0] OP_WRITE    = 2'd1;
    localparam logic [1:0] OP_SHIFT_DN = 2'd2;
    localparam logic [1:0] OP_SHIFT_UP = 2'd3;

    // Command broadcast to every cell in the row
    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] pos;
        logic [WIDTH-1:0] item;
        logic [IDX_W-1:0] rd_pos;
    } cell_cmd_t;

endpackage

### design/ilir_if.sv
// Request and response channel interfaces of the indexed list unit.
interface ilir_req_if;
    import ilir_pkg::*;

    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] item_value;

    modport source (output valid, output req_type, output index, output item_value,
                    input ready);
    modport sink   (input valid, input req_type, input index, input item_value,
                    output ready);
endinterface

interface ilir_rsp_if;
    import ilir_pkg::*;

    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  read_value;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;

    modport source (output valid, output read_value, output status, output count,
                    input ready);
    modport sink   (input valid, input read_value, input status, input count,
                    output ready);
endinterface

### design/ilir_cell.sv
// One storage cell of the list: holds a word, writes, or takes a neighbor's word.
module ilir_cell (
    input  logic                       clk,
    input  logic [ilir_pkg::IDX_W-1:0] cell_id,
    input  ilir_pkg::cell_cmd_t        cmd,
    input  logic [ilir_pkg::WIDTH-1:0] left_word,
    input  logic [ilir_pkg::WIDTH-1:0] right_word,
    output logic [ilir_pkg::WIDTH-1:0] word,
    output logic [ilir_pkg::WIDTH-1:0] rd_word
);
    import ilir_pkg::*;

    logic [WIDTH-1:0] word_reg;
    logic [WIDTH-1:0] word_next;
    logic             at_pos;
    logic             past_pos;

    assign at_pos   = (cell_id == cmd.pos);
    assign past_pos = (cell_id > cmd.pos);

    // next word from the broadcast command
    always_comb
    begin
        word_next = word_reg;
        case (cmd.op)
            OP_WRITE:
            begin
                if (at_pos)
                    word_next = cmd.item;
            end
            OP_SHIFT_DN:
            begin
                if (at_pos || past_pos)
                    word_next = right_word;
            end
            OP_SHIFT_UP:
            begin
                if (at_pos)
                    word_next = cmd.item;
                else if (past_pos)
                    word_next = left_word;
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word    = word_reg;
    // drive the shared read bus only when selected
    assign rd_word = (cell_id == cmd.rd_pos) ? word_reg : '0;

endmodule

### design/indexed_list_insert_remove_unit.sv
// Top level of the indexed list unit: request decode, count, cell row and response register.
// Keeps an ordered list of up to DEPTH words in a row of cells; insert and remove shift the
// cells from the target slot upward toward or away from it all at once, and a new request is
// taken every cycle while the response register is free or being drained. The response is
// registered and appears in the cycle after the request is accepted. Entries are read
// only below the live count; clear just empties the count, old words are overwritten later.
module indexed_list_insert_remove_unit (
    input  logic       clk,
    input  logic       rst_n,
    ilir_req_if.sink   req,
    ilir_rsp_if.source rsp
);
    import ilir_pkg::*;

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                out_valid_reg;
    logic [VALUE_W-1:0]  read_value_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [COUNT_W-1:0]  count_out_reg;

    logic                accept;
    cell_cmd_t           cmd;
    logic [1:0]          op_sel;
    logic [IDX_W-1:0]    pos_sel;
    logic [IDX_W-1:0]    rd_pos_sel;
    logic                use_read;
    logic [STATUS_W-1:0] status_new;
    logic [CMP_W-1:0]    idx_c;
    logic [CMP_W-1:0]    cnt_c;
    logic [CNT_W-1:0]    cnt_m1;
    logic                full;
    logic                empty;
    logic [63:0]         item_wide;
    logic [63:0]         rd_wide;
    logic [31:0]         cnt_wide;
    logic [WIDTH-1:0]    words    [DEPTH];
    logic [WIDTH-1:0]    rd_parts [DEPTH];
    logic [WIDTH-1:0]    rd_bus;
    logic [VALUE_W-1:0]  read_value_new;

    // handshake: response register frees up as it drains
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign idx_c     = CMP_W'(req.index);
    assign cnt_c     = CMP_W'(count_reg);
    assign cnt_m1    = count_reg - 1'b1;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign item_wide = 64'(req.item_value);

    // request decode
    always_comb
    begin
        op_sel     = OP_HOLD;
        pos_sel    = idx_c[IDX_W-1:0];
        rd_pos_sel = idx_c[IDX_W-1:0];
        use_read   = 1'b0;
        status_new = ST_OK;
        count_next = count_reg;
        case (req.req_type)
            REQ_APPEND:
            begin
                if (full)
                    status_new = ST_FULL;
                else
                begin
                    op_sel     = OP_WRITE;
                    pos_sel    = count_reg[IDX_W-1:0];
                    count_next = count_reg + 1'b1;
                end
            end
            REQ_SET:
            begin
                if (idx_c >= cnt_c)
                    status_new = ST_INDEX;
                else
                    op_sel = OP_WRITE;
            end
            REQ_GET:
            begin
                if (idx_c >= cnt_c)
                    status_new = ST_INDEX;
                else
                    use_read = 1'b1;
            end
            REQ_REMOVE:
            begin
                if (idx_c >= cnt_c)
                    status_new = ST_INDEX;
                else
                begin
                    use_read   = 1'b1;
                    op_sel     = OP_SHIFT_DN;
                    count_next = cnt_m1;
                end
            end
            REQ_POP:
            begin
                if (empty)
                    status_new = ST_EMPTY;
                else
                begin
                    use_read   = 1'b1;
                    rd_pos_sel = cnt_m1[IDX_W-1:0];
                    count_next = cnt_m1;
                end
            end
            REQ_INSERT:
            begin
                if (idx_c > cnt_c)
                    status_new = ST_INDEX;
                else if (full)
                    status_new = ST_FULL;
                else
                begin
                    op_sel     = OP_SHIFT_UP;
                    count_next = count_reg + 1'b1;
                end
            end
            REQ_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // command to the row; cells only change on an accepted request
    always_comb
    begin
        cmd.op     = accept ? op_sel : OP_HOLD;
        cmd.pos    = pos_sel;
        cmd.item   = item_wide[WIDTH-1:0];
        cmd.rd_pos = rd_pos_sel;
    end

    // row of cells, each linked to its two neighbors
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WIDTH-1:0] left_w;
        logic [WIDTH-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_inner_l
            assign left_w = words[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_inner_r
            assign right_w = words[i+1];
        end

        ilir_cell u_cell (
            .clk        (clk),
            .cell_id    (IDX_W'(i)),
            .cmd        (cmd),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (words[i]),
            .rd_word    (rd_parts[i])
        );
    end

    // OR together the read bus
    always_comb
    begin
        rd_bus = '0;
        for (int k = 0; k < DEPTH; k++)
            rd_bus = rd_bus | rd_parts[k];
    end

    assign rd_wide        = use_read ? 64'(rd_bus) : 64'd0;
    assign read_value_new = rd_wide[VALUE_W-1:0];
    assign cnt_wide       = 32'(count_next);

    // count and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                count_reg <= count_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_value_reg <= read_value_new;
            status_reg     <= status_new;
            count_out_reg  <= cnt_wide[COUNT_W-1:0];
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = read_value_reg;
    assign rsp.status     = status_reg;
    assign rsp.count      = count_out_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    a_accept_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted request produced no response word");

    a_fail_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status_new != ST_OK) |=> (count_reg == $past(count_reg)))
        else $error("failed request changed the count");

    a_count_reported: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (count_out_reg == COUNT_W'(count_reg)))
        else $error("reported count differs from live count");

endmodule

### dv/tb_indexed_list_insert_remove_unit.sv
// Testbench for the indexed list unit: directed and random requests checked against a shadow list.
`timescale 1ns / 1ps

module tb_indexed_list_insert_remove_unit;
    import ilir_pkg::*;

    // Request code with no operation behind it
    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;
    localparam int IDLE_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [VALUE_W-1:0]  read_value;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } list_result_t;

    logic clk;
    logic rst_n;

    ilir_req_if req_ch ();
    ilir_rsp_if rsp_ch ();

    indexed_list_insert_remove_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // Shadow copy of the list
    logic [WIDTH-1:0] list_words [DEPTH];
    int unsigned      list_len;

    list_result_t pending_results [$];
    int           mismatches;
    int           send_idle_pct;
    int           stall_pct;
    int           hold_left;
    bit           growing;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Shadow list update for one accepted request
    function automatic list_result_t apply_request(input logic [REQ_W-1:0] op,
                                                   input logic [INDEX_W-1:0] idx,
                                                   input logic [VALUE_W-1:0] value);
        list_result_t res;
        int pos;
        res.read_value = '0;
        res.status     = ST_OK;
        pos            = int'(idx);
        case (op)
            REQ_APPEND:
                if (list_len >= DEPTH)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    list_words[list_len] = value[WIDTH-1:0];
                    list_len++;
                end
            REQ_SET:
                if (pos >= list_len)
                    res.status = ST_INDEX;
                else
                    list_words[pos] = value[WIDTH-1:0];
            REQ_GET:
                if (pos >= list_len)
                    res.status = ST_INDEX;
                else
                    res.read_value = VALUE_W'(list_words[pos]);
            REQ_REMOVE:
                if (pos >= list_len)
                begin
                    res.status = ST_INDEX;
                end
                else
                begin
                    res.read_value = VALUE_W'(list_words[pos]);
                    for (int i = pos; i + 1 < int'(list_len); i++)
                        list_words[i] = list_words[i + 1];
                    list_len--;
                end
            REQ_POP:
                if (list_len == 0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    res.read_value = VALUE_W'(list_words[list_len - 1]);
                    list_len--;
                end
            REQ_INSERT:
                if (pos > list_len)
                begin
                    res.status = ST_INDEX;
                end
                else if (list_len >= DEPTH)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    for (int i = list_len; i > pos; i--)
                        list_words[i] = list_words[i - 1];
                    list_words[pos] = value[WIDTH-1:0];
                    list_len++;
                end
            REQ_CLEAR:
                begin
                    foreach (list_words[i])
                        list_words[i] = '0;
                    list_len = 0;
                end
            default: ;
        endcase
        res.count = COUNT_W'(list_len);
        return res;
    endfunction

    // Offer one word, wait for acceptance, queue its expected response
    task automatic send_word(input logic [REQ_W-1:0] op, input logic [INDEX_W-1:0] idx,
                             input logic [VALUE_W-1:0] value);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= op;
        req_ch.index      <= idx;
        req_ch.item_value <= value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_results.push_back(apply_request(op, idx, value));
    endtask

    // Sender goes quiet until every response is back
    task automatic idle_until_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly in-range indexes, some at the boundary, some anywhere
    function automatic logic [INDEX_W-1:0] pick_index(input int unsigned span);
        case ($urandom_range(9))
            0:       return INDEX_W'($urandom_range(255));
            1:       return INDEX_W'(list_len + $urandom_range(1));
            default: return (span == 0) ? '0 : INDEX_W'($urandom_range(span - 1));
        endcase
    endfunction

    // One random request, biased to sweep the list between empty and full
    task automatic send_random_word();
        int r;
        logic [REQ_W-1:0] op;
        if (list_len == DEPTH)
            growing = 1'b0;
        else if (list_len == 0 || $urandom_range(99) < 3)
            growing = (list_len == 0) ? 1'b1 : ~growing;
        r = $urandom_range(99);
        if (r < 2)
            op = REQ_UNUSED;
        else if (r < 4)
            op = REQ_CLEAR;
        else if ($urandom_range(99) < (growing ? 60 : 20))
            op = $urandom_range(1) ? REQ_APPEND : REQ_INSERT;
        else
            case ($urandom_range(3))
                0:       op = REQ_SET;
                1:       op = REQ_GET;
                2:       op = REQ_REMOVE;
                default: op = REQ_POP;
            endcase
        send_word(op, pick_index(op == REQ_INSERT ? list_len + 1 : list_len), pick_value());
    endtask

    task automatic run_random(input int n_words);
        repeat (n_words)
            send_random_word();
    endtask

    // Every operation, field extremes, empty list and bad indexes
    task automatic test_directed_ops();
        send_word(REQ_POP,    8'd0,   32'h1234_5678);
        send_word(REQ_GET,    8'd0,   32'h0);
        send_word(REQ_REMOVE, 8'd0,   32'h0);
        send_word(REQ_SET,    8'd0,   32'hFFFF_FFFF);
        send_word(REQ_INSERT, 8'd1,   32'hDEAD_BEEF);
        send_word(REQ_INSERT, 8'd0,   32'h0000_0000);
        send_word(REQ_APPEND, 8'd255, 32'hFFFF_FFFF);
        send_word(REQ_INSERT, 8'd1,   32'hA5A5_A5A5);
        send_word(REQ_INSERT, 8'd3,   32'h5A5A_5A5A);
        send_word(REQ_GET,    8'd1,   32'h0);
        send_word(REQ_GET,    8'd3,   32'h0);
        send_word(REQ_GET,    8'd4,   32'h0);
        send_word(REQ_GET,    8'd255, 32'hFFFF_FFFF);
        send_word(REQ_SET,    8'd0,   32'h8000_0001);
        send_word(REQ_SET,    8'd4,   32'h1);
        send_word(REQ_REMOVE, 8'd1,   32'h0);
        send_word(REQ_UNUSED, 8'd255, 32'hFFFF_FFFF);
        send_word(REQ_INSERT, 8'd5,   32'h7);
        send_word(REQ_REMOVE, 8'd2,   32'h0);
        send_word(REQ_POP,    8'd0,   32'h0);
        send_word(REQ_CLEAR,  8'd0,   32'h0);
        send_word(REQ_GET,    8'd0,   32'h0);
        send_word(REQ_POP,    8'd0,   32'h0);
    endtask

    // Fill to capacity, hit the full status, then drain past empty
    task automatic test_full_list();
        send_word(REQ_CLEAR, 8'd0, 32'h0);
        repeat (DEPTH)
            send_word(REQ_APPEND, 8'd0, pick_value());
        send_word(REQ_APPEND, 8'd0,             32'hFFFF_FFFF);
        send_word(REQ_INSERT, INDEX_W'(DEPTH),     32'h1);
        send_word(REQ_INSERT, INDEX_W'(DEPTH + 1), 32'h2);
        send_word(REQ_INSERT, 8'd0,             32'h3);
        send_word(REQ_SET,    INDEX_W'(DEPTH - 1), 32'hCAFE_F00D);
        send_word(REQ_GET,    INDEX_W'(DEPTH - 1), 32'h0);
        send_word(REQ_REMOVE, 8'd0,             32'h0);
        send_word(REQ_INSERT, 8'd0,             32'hFFFF_FFFF);
        repeat (DEPTH + 1)
            send_word(REQ_POP, 8'd0, 32'h0);
    endtask

    // Receiver holds off for a long stretch while requests keep coming
    task automatic test_backpressure_fill();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = 300;
        run_random(30);
    endtask

    // Sender stops until the response path is empty, then resumes
    task automatic test_drain_pause();
        send_idle_pct = 0;
        stall_pct     = 40;
        run_random(20);
        idle_until_drained();
        run_random(20);
    endtask

    task automatic test_random_no_idle();
        send_idle_pct = 0;
        stall_pct     = 0;
        run_random(200);
    endtask

    task automatic test_random_sender_idle();
        send_idle_pct = 85;
        stall_pct     = 0;
        run_random(200);
    endtask

    task automatic test_random_receiver_stall();
        send_idle_pct = 0;
        stall_pct     = 85;
        run_random(200);
    endtask

    task automatic test_random_both_idle();
        send_idle_pct = 27;
        stall_pct     = 27;
        run_random(200);
    endtask

    task automatic note_mismatch(input string what, input list_result_t want,
                                 input list_result_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: %s exp rd=%h st=%0d cnt=%0d got rd=%h st=%0d cnt=%0d",
                     $realtime, what, want.read_value, want.status, want.count,
                     got.read_value, got.status, got.count);
    endtask

    // Response ready, with random stalls and a counted hold-off
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Compare each response word against the oldest expectation
    always @(posedge clk)
    begin : check_response
        list_result_t want;
        list_result_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.read_value = rsp_ch.read_value;
            got.status     = rsp_ch.status;
            got.count      = rsp_ch.count;
            if (pending_results.size() == 0)
            begin
                want = '{default: '0};
                note_mismatch("unexpected word", want, got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.read_value !== want.read_value)
                    note_mismatch("read_value", want, got);
                if (got.status !== want.status)
                    note_mismatch("status", want, got);
                if (got.count !== want.count)
                    note_mismatch("count", want, got);
            end
        end
    end

    // Watchdog on cycles with no word moving on either channel
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_APPEND;
        req_ch.index      = '0;
        req_ch.item_value = '0;
        rst_n             = 1'b0;
        mismatches        = 0;
        send_idle_pct     = 0;
        stall_pct         = 0;
        hold_left         = 0;
        growing           = 1'b1;
        list_len          = 0;
        foreach (list_words[i])
            list_words[i] = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_ops();
        test_full_list();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_backpressure_fill();
        test_drain_pause();

        // Let the last responses drain
        send_idle_pct = 0;
        stall_pct     = 0;
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### indexed_list_insert_remove_unit.f
design/ilir_pkg.sv
design/ilir_if.sv
design/ilir_cell.sv
design/indexed_list_insert_remove_unit.sv
dv/tb_indexed_list_insert_remove_unit.sv
